[design/c3f_pkg.sv]
`timescale 1ns / 1ps

package c3f_pkg;

  // Geometry
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int LEN_W     = 11;
  localparam int CMP_W     = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int MIN_LEN   = 3;
  localparam int WIN       = 3;

  // Datapath widths
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 8;
  localparam int KROW_W  = WIN * COEF_W;
  localparam int PROD_W  = COEF_W + PIX_W + 1;
  localparam int CSUM_W  = PROD_W + 2;
  localparam int TOT_W   = CSUM_W + 2;
  localparam int OUT_W   = 16;
  localparam int DIV_SH  = 4;
  localparam int DIV_BIAS = (1 << DIV_SH) - 1;

  // Row counter
  localparam logic [1:0] ROWS_FULL = 2'd2;

  // Output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Register file
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_ROW_LENGTH    = 2'd0,
    REG_KERNEL_TOP    = 2'd1,
    REG_KERNEL_MIDDLE = 2'd2,
    REG_KERNEL_BOTTOM = 2'd3
  } reg_idx_e;

  localparam logic [LEN_W-1:0]  ROW_LENGTH_RST = 11'd12;
  localparam logic [KROW_W-1:0] KERNEL_TOP_RST = 24'h010201;
  localparam logic [KROW_W-1:0] KERNEL_MID_RST = 24'h020402;
  localparam logic [KROW_W-1:0] KERNEL_BOT_RST = 24'h010201;

  // Channel payloads
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    row_end;
  } out_item_t;

  // One window column, oldest row on top
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pix_col_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] top;
    logic signed [COEF_W-1:0] mid;
    logic signed [COEF_W-1:0] bot;
  } coef_col_t;

endpackage

[design/conv3x3_valid_filter.sv]
`timescale 1ns / 1ps
// Pipeline: an accepted pixel passes the line-buffer read register, the window cell,
//   the product and column-sum registers, and is then pushed into the output queue.
// Throughput: one pixel per cycle; in_stall_o rises only when the 8 result credits
//   (output queue plus pipeline) are all taken by results not yet delivered.
// Reset: counters, window and queue cleared; row length 12, 1-2-1 Gaussian kernel.
//   The two line buffers are not cleared and hold garbage until written.

module conv3x3_valid_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  c3f_pkg::in_item_t                   in_item_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output c3f_pkg::out_item_t                  out_item_o,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [c3f_pkg::PADDR_W-1:0]         paddr,
  input  logic [c3f_pkg::PDATA_W-1:0]         pwdata,
  output logic [c3f_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  // Configuration registers
  logic [c3f_pkg::LEN_W-1:0]   row_length_q;
  logic [c3f_pkg::KROW_W-1:0]  kern_top_q, kern_mid_q, kern_bot_q;
  c3f_pkg::reg_idx_e           reg_idx;
  logic                        cfg_wr;

  // Input side
  logic                         in_acc;
  logic [c3f_pkg::ADDR_W-1:0]   col_q, col_d, col_cur;
  logic [1:0]                   rows_q, rows_d, rows_cur;
  logic [c3f_pkg::CMP_W-1:0]    len_raw, len_eff, col_p1;
  logic                         last_cur, res_cur;

  // Stage 1: line buffer read data
  logic                         s1_v_q, s1_res_q, s1_last_q, fwd_q;
  logic [c3f_pkg::PIX_W-1:0]    s1_px_q, fwd_up_q, fwd_lo_q;
  logic [c3f_pkg::ADDR_W-1:0]   s1_col_q;
  logic [c3f_pkg::PIX_W-1:0]    up_rd, lo_rd, up1, lo1;

  // Stages 2..4: window, products, column sums
  logic                         s2_v_q, s3_v_q, s4_v_q;
  logic                         s2_last_q, s3_last_q, s4_last_q;

  // Window cells
  c3f_pkg::pix_col_t                    new_col;
  c3f_pkg::pix_col_t                    cell_col [c3f_pkg::WIN];
  c3f_pkg::coef_col_t                   cell_coef [c3f_pkg::WIN];
  logic signed [c3f_pkg::CSUM_W-1:0]    cell_sum [c3f_pkg::WIN];

  // Final sum
  logic signed [c3f_pkg::TOT_W-1:0]     total, total_adj, total_q16;
  c3f_pkg::out_item_t                   res_item;

  // Credits and output
  logic [c3f_pkg::FIFO_CNT_W-1:0]       occ_q, occ_d;
  logic                                 pop;

  // ---------------------------------------------------------------
  // Register port
  assign pready  = 1'b1;
  assign reg_idx = c3f_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= c3f_pkg::ROW_LENGTH_RST;
      kern_top_q   <= c3f_pkg::KERNEL_TOP_RST;
      kern_mid_q   <= c3f_pkg::KERNEL_MID_RST;
      kern_bot_q   <= c3f_pkg::KERNEL_BOT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        c3f_pkg::REG_ROW_LENGTH:    row_length_q <= pwdata[c3f_pkg::LEN_W-1:0];
        c3f_pkg::REG_KERNEL_TOP:    kern_top_q   <= pwdata[c3f_pkg::KROW_W-1:0];
        c3f_pkg::REG_KERNEL_MIDDLE: kern_mid_q   <= pwdata[c3f_pkg::KROW_W-1:0];
        c3f_pkg::REG_KERNEL_BOTTOM: kern_bot_q   <= pwdata[c3f_pkg::KROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      c3f_pkg::REG_ROW_LENGTH:    prdata = c3f_pkg::PDATA_W'(row_length_q);
      c3f_pkg::REG_KERNEL_TOP:    prdata = c3f_pkg::PDATA_W'(kern_top_q);
      c3f_pkg::REG_KERNEL_MIDDLE: prdata = c3f_pkg::PDATA_W'(kern_mid_q);
      c3f_pkg::REG_KERNEL_BOTTOM: prdata = c3f_pkg::PDATA_W'(kern_bot_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Position tracking
  assign in_stall_o = (occ_q == c3f_pkg::FIFO_CNT_W'(c3f_pkg::FIFO_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;

  assign col_cur  = in_item_i.frame_start ? '0 : col_q;
  assign rows_cur = in_item_i.frame_start ? '0 : rows_q;

  // Clamp row length into [3, MAX_WIDTH]
  assign len_raw = c3f_pkg::CMP_W'(row_length_q);
  always_comb begin
    if (len_raw < c3f_pkg::CMP_W'(c3f_pkg::MIN_LEN)) begin
      len_eff = c3f_pkg::CMP_W'(c3f_pkg::MIN_LEN);
    end else if (len_raw > c3f_pkg::CMP_W'(c3f_pkg::MAX_WIDTH)) begin
      len_eff = c3f_pkg::CMP_W'(c3f_pkg::MAX_WIDTH);
    end else begin
      len_eff = len_raw;
    end
  end

  assign col_p1   = c3f_pkg::CMP_W'(col_cur) + c3f_pkg::CMP_W'(1);
  assign last_cur = (col_p1 >= len_eff);
  assign res_cur  = (rows_cur == c3f_pkg::ROWS_FULL) &&
                    (col_cur >= c3f_pkg::ADDR_W'(c3f_pkg::WIN - 1));

  always_comb begin
    col_d  = c3f_pkg::ADDR_W'(col_p1);
    rows_d = rows_cur;
    if (last_cur) begin
      col_d = '0;
      if (rows_cur != c3f_pkg::ROWS_FULL) begin
        rows_d = rows_cur + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      rows_q <= '0;
    end else if (in_acc) begin
      col_q  <= col_d;
      rows_q <= rows_d;
    end
  end

  // ---------------------------------------------------------------
  // Line buffers: read at accept, written back in the cycle after
  c3f_ram #(
    .WIDTH (c3f_pkg::PIX_W),
    .DEPTH (c3f_pkg::MAX_WIDTH)
  ) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_col_q),
    .wdata_i (lo1),
    .re_i    (in_acc),
    .raddr_i (col_cur),
    .rdata_o (up_rd)
  );

  c3f_ram #(
    .WIDTH (c3f_pkg::PIX_W),
    .DEPTH (c3f_pkg::MAX_WIDTH)
  ) u_line_lower (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (in_acc),
    .raddr_i (col_cur),
    .rdata_o (lo_rd)
  );

  // Bypass when the read hits the column being written in the same cycle
  assign up1 = fwd_q ? fwd_up_q : up_rd;
  assign lo1 = fwd_q ? fwd_lo_q : lo_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q   <= in_item_i.pixel;
      s1_col_q  <= col_cur;
      s1_res_q  <= res_cur;
      s1_last_q <= last_cur;
      fwd_q     <= s1_v_q && (s1_col_q == col_cur);
      fwd_up_q  <= lo1;
      fwd_lo_q  <= s1_px_q;
    end
  end

  // ---------------------------------------------------------------
  // Window: newest column enters the right cell, oldest sits on the left
  assign new_col.top = up1;
  assign new_col.mid = lo1;
  assign new_col.bot = s1_px_q;

  for (genvar k = 0; k < c3f_pkg::WIN; k++) begin : g_cell
    assign cell_coef[k].top = $signed(kern_top_q[c3f_pkg::COEF_W*k +: c3f_pkg::COEF_W]);
    assign cell_coef[k].mid = $signed(kern_mid_q[c3f_pkg::COEF_W*k +: c3f_pkg::COEF_W]);
    assign cell_coef[k].bot = $signed(kern_bot_q[c3f_pkg::COEF_W*k +: c3f_pkg::COEF_W]);

    if (k == c3f_pkg::WIN - 1) begin : g_head
      c3f_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (s1_v_q),
        .col_i   (new_col),
        .coef_i  (cell_coef[k]),
        .col_o   (cell_col[k]),
        .sum_o   (cell_sum[k])
      );
    end else begin : g_body
      c3f_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (s1_v_q),
        .col_i   (cell_col[k+1]),
        .coef_i  (cell_coef[k]),
        .col_o   (cell_col[k]),
        .sum_o   (cell_sum[k])
      );
    end
  end

  // Result tags follow the cell pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q && s1_res_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_last_q <= s1_last_q;
    s3_last_q <= s2_last_q;
    s4_last_q <= s3_last_q;
  end

  // Sum of columns, divide by 16 toward zero
  assign total = c3f_pkg::TOT_W'(cell_sum[0]) + c3f_pkg::TOT_W'(cell_sum[1])
               + c3f_pkg::TOT_W'(cell_sum[2]);
  assign total_adj = total + (total[c3f_pkg::TOT_W-1] ?
                              c3f_pkg::TOT_W'(c3f_pkg::DIV_BIAS) : '0);
  assign total_q16 = total_adj >>> c3f_pkg::DIV_SH;

  assign res_item.filtered = total_q16[c3f_pkg::OUT_W-1:0];
  assign res_item.row_end  = s4_last_q;

  // ---------------------------------------------------------------
  // Output queue and credit count
  c3f_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s4_v_q),
    .push_item_i (res_item),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .item_o      (out_item_o)
  );

  assign pop = out_valid_o && !out_stall_i;

  always_comb begin
    occ_d = occ_q;
    if ((in_acc && res_cur) && !pop) begin
      occ_d = occ_q + c3f_pkg::FIFO_CNT_W'(1);
    end else if (!(in_acc && res_cur) && pop) begin
      occ_d = occ_q - c3f_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // A result in the last pipeline stage holds a credit
  a_inflight_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |-> occ_q != '0)
    else $error("result in flight without a credit");

  // Queued results are always covered by credits
  a_queue_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != '0)
    else $error("queued item without a credit");

endmodule

[design/c3f_ram.sv]
`timescale 1ns / 1ps

module c3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port (read-first)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/c3f_cell.sv]
`timescale 1ns / 1ps

module c3f_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 shift_i,
  input  c3f_pkg::pix_col_t                    col_i,
  input  c3f_pkg::coef_col_t                   coef_i,
  output c3f_pkg::pix_col_t                    col_o,
  output logic signed [c3f_pkg::CSUM_W-1:0]    sum_o
);

  c3f_pkg::pix_col_t                     col_q;
  logic signed [c3f_pkg::PROD_W-1:0]     prod_top_q, prod_mid_q, prod_bot_q;
  logic signed [c3f_pkg::PROD_W-1:0]     prod_top_d, prod_mid_d, prod_bot_d;
  logic signed [c3f_pkg::CSUM_W-1:0]     sum_q, sum_d;

  // Window column: takes the neighbor's column on every pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  // Three taps, pixels zero-extended to signed
  assign prod_top_d = coef_i.top * $signed({1'b0, col_q.top});
  assign prod_mid_d = coef_i.mid * $signed({1'b0, col_q.mid});
  assign prod_bot_d = coef_i.bot * $signed({1'b0, col_q.bot});

  assign sum_d = c3f_pkg::CSUM_W'(prod_top_q) + c3f_pkg::CSUM_W'(prod_mid_q)
               + c3f_pkg::CSUM_W'(prod_bot_q);

  // Product and column-sum stages run every cycle
  always_ff @(posedge clk_i) begin
    prod_top_q <= prod_top_d;
    prod_mid_q <= prod_mid_d;
    prod_bot_q <= prod_bot_d;
    sum_q      <= sum_d;
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

[design/c3f_fifo.sv]
`timescale 1ns / 1ps

module c3f_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  c3f_pkg::out_item_t  push_item_i,
  input  logic                pop_i,
  output logic                valid_o,
  output c3f_pkg::out_item_t  item_o
);

  c3f_pkg::out_item_t                  mem_q [c3f_pkg::FIFO_DEPTH];
  logic [c3f_pkg::FIFO_PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [c3f_pkg::FIFO_CNT_W-1:0]      count_q, count_d;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + c3f_pkg::FIFO_CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - c3f_pkg::FIFO_CNT_W'(1);
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + c3f_pkg::FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + c3f_pkg::FIFO_PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // The upstream credit count must keep the queue from overflowing
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < c3f_pkg::FIFO_CNT_W'(c3f_pkg::FIFO_DEPTH) || pop_i))
    else $error("item pushed into full output queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("item popped from empty output queue");

endmodule
